// ===== src/pst_pkg.sv =====
// Shared types and constants for the per-sample genotype tally.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pst_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int IDX_W       = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = 32;
    localparam int COV_W       = 48;
    localparam int DEPTH_W     = 16;
    localparam int CFG_IDX_W   = 3;

    localparam logic [DEPTH_W-1:0] MAX_DEPTH_RST = DEPTH_W'(1000);

    typedef enum logic [CFG_IDX_W-1:0] {
        t_cfg_count_passing = 3'd0,
        t_cfg_count_failing = 3'd1,
        t_cfg_indel_mode    = 3'd2,
        t_cfg_min_depth     = 3'd3,
        t_cfg_max_depth     = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        t_op_update = 1'b0,
        t_op_read   = 1'b1
    } t_opcode;

    typedef struct packed {
        logic [CNT_W-1:0] homref;
        logic [CNT_W-1:0] het;
        logic [CNT_W-1:0] homalt;
        logic [CNT_W-1:0] missing;
        logic [CNT_W-1:0] passing;
        logic [CNT_W-1:0] ti;
        logic [CNT_W-1:0] tv;
        logic [CNT_W-1:0] dcount;
        logic [COV_W-1:0] cov;
    } t_tally;

endpackage

`default_nettype wire

// ===== src/per_sample_genotype_tally.sv =====
// Per-sample genotype tally: counter store with read-modify-write pipeline.
// Depends on pst_pkg.
//
//  channel | direction | handshake           | payload
//  in      | input     | i_valid / o_stall   | opcode, sample, site flag, genotype, depth, bases
//  out     | output    | o_valid / i_stall   | nine sample counters and site total
//  cfg     | input     | i_cfg_we            | i_cfg_idx, i_cfg_wdata
//
// One item per cycle while o_stall is low. Stage 0 reads the sample's entry and
// classes the item, stage 1 adds the increments and writes back; a one-entry
// forward register covers back-to-back items on the same sample. A read result
// passes from the stage 1 registers into the output register; a read stalls while
// that register is full and stalled. After reset a clearing pass zeroes the store,
// one entry per cycle, with o_stall high; config writes are taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module per_sample_genotype_tally
    import pst_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_stall,
    input  wire                    i_opcode,
    input  wire  [IDX_W-1:0]       i_sample_index,
    input  wire                    i_first_of_site,
    input  wire                    i_filter_passed,
    input  wire  signed [6:0]      i_first_allele,
    input  wire  signed [6:0]      i_second_allele,
    input  wire  signed [31:0]     i_read_depth,
    input  wire  signed [2:0]      i_ref_base,
    input  wire  signed [2:0]      i_first_alt_base,
    input  wire  signed [2:0]      i_second_alt_base,
    input  wire                    i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire  [DEPTH_W-1:0]     i_cfg_wdata,
    output logic                   o_valid,
    input  wire                    i_stall,
    output logic [CNT_W-1:0]       o_homref_total,
    output logic [CNT_W-1:0]       o_het_total,
    output logic [CNT_W-1:0]       o_homalt_total,
    output logic [CNT_W-1:0]       o_missing_total,
    output logic [CNT_W-1:0]       o_passing_variant_total,
    output logic [CNT_W-1:0]       o_transition_total,
    output logic [CNT_W-1:0]       o_transversion_total,
    output logic [CNT_W-1:0]       o_depth_sample_total,
    output logic [COV_W-1:0]       o_coverage_total,
    output logic [CNT_W-1:0]       o_site_total
);

    function automatic logic is_ti(input logic signed [2:0] rb, input logic signed [2:0] ab);
        logic signed [3:0] d;
        d = 4'(rb) - 4'(ab);
        return (d == 4'sd2) || (d == -4'sd2);
    endfunction

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                                 input logic [1:0] inc);
        logic [CNT_W:0] s;
        s = {1'b0, c} + {{(CNT_W-1){1'b0}}, inc};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    // configuration
    logic               r_count_passing, r_count_failing, r_indel_mode;
    logic [DEPTH_W-1:0] r_min_depth, r_max_depth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_passing <= 1'b1;
            r_count_failing <= 1'b0;
            r_indel_mode    <= 1'b0;
            r_min_depth     <= '0;
            r_max_depth     <= MAX_DEPTH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                t_cfg_count_passing: r_count_passing <= i_cfg_wdata[0];
                t_cfg_count_failing: r_count_failing <= i_cfg_wdata[0];
                t_cfg_indel_mode:    r_indel_mode    <= i_cfg_wdata[0];
                t_cfg_min_depth:     r_min_depth     <= i_cfg_wdata;
                t_cfg_max_depth:     r_max_depth     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // control
    logic             r_clearing;
    logic [IDX_W-1:0] r_clr_addr;
    logic             r_s1_valid;
    logic             r_s1_read;
    logic             s1_go;
    logic             accept;

    assign s1_go   = r_s1_valid && !(r_s1_read && o_valid && i_stall);
    assign o_stall = r_clearing || (r_s1_valid && !s1_go);
    assign accept  = i_valid && !o_stall;

    // stage 0: classing
    logic       a1_ok, a2_ok, en;
    logic       c_homref, c_het, c_homalt, c_missing, c_depth;
    logic       ti1, ti2;
    logic [1:0] c_ti, c_tv;

    always_comb begin
        a1_ok     = !i_first_allele[6];
        a2_ok     = !i_second_allele[6];
        en        = (i_opcode == t_op_update) &&
                    ((i_filter_passed && r_count_passing) ||
                     (!i_filter_passed && r_count_failing));
        c_homref  = (i_first_allele == 7'sd0) && (i_second_allele == 7'sd0);
        c_het     = !c_homref && a1_ok && a2_ok && (i_first_allele != i_second_allele);
        c_homalt  = !c_homref && a1_ok && a2_ok && (i_first_allele == i_second_allele);
        c_missing = !(a1_ok && a2_ok);
        c_depth   = (i_read_depth >= $signed({16'b0, r_min_depth})) &&
                    (i_read_depth <= $signed({16'b0, r_max_depth}));
        ti1       = is_ti(i_ref_base, i_first_alt_base);
        ti2       = is_ti(i_ref_base, i_second_alt_base);
        c_ti      = 2'b00;
        c_tv      = 2'b00;
        if (!r_indel_mode) begin
            if (c_het) begin
                c_ti = {1'b0, ti2};
                c_tv = {1'b0, !ti2};
            end else if (c_homalt) begin
                c_ti = {1'b0, ti1} + {1'b0, ti2};
                c_tv = {1'b0, !ti1} + {1'b0, !ti2};
            end
        end
    end

    // stage 1 registers
    logic               r_s1_en;
    logic [IDX_W-1:0]   r_s1_idx;
    logic               r_s1_homref, r_s1_het, r_s1_homalt, r_s1_missing;
    logic               r_s1_pass, r_s1_depth_ok;
    logic [1:0]         r_s1_ti, r_s1_tv;
    logic [DEPTH_W-1:0] r_s1_depth;
    logic [CNT_W-1:0]   r_s1_site;
    logic [CNT_W-1:0]   r_site;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_site     <= '0;
        end else begin
            if (accept)
                r_s1_valid <= 1'b1;
            else if (s1_go)
                r_s1_valid <= 1'b0;
            if (accept && (i_opcode == t_op_update) && i_first_of_site)
                r_site <= sat_add(r_site, 2'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_read     <= (i_opcode == t_op_read);
            r_s1_en       <= en;
            r_s1_idx      <= i_sample_index;
            r_s1_homref   <= c_homref;
            r_s1_het      <= c_het;
            r_s1_homalt   <= c_homalt;
            r_s1_missing  <= c_missing;
            r_s1_pass     <= i_filter_passed && (c_het || c_homalt);
            r_s1_depth_ok <= c_depth;
            r_s1_ti       <= c_ti;
            r_s1_tv       <= c_tv;
            r_s1_depth    <= i_read_depth[DEPTH_W-1:0];
            r_s1_site     <= r_site;
        end
    end

    // counter store
    t_tally           mem [MAX_SAMPLES];
    t_tally           r_rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_tally           wr_data;
    logic             r_fwd_valid;
    logic [IDX_W-1:0] r_fwd_addr;
    t_tally           r_fwd_data;
    t_tally           cur, upd;
    logic [COV_W:0]   cov_sum;

    always_ff @(posedge i_clk) begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (accept)
            r_rd_data <= mem[i_sample_index];
    end

    always_comb begin
        cur = (r_fwd_valid && (r_fwd_addr == r_s1_idx)) ? r_fwd_data : r_rd_data;
        upd = cur;
        cov_sum = {1'b0, cur.cov} + {{(COV_W-DEPTH_W+1){1'b0}}, r_s1_depth};
        if (r_s1_depth_ok) begin
            upd.cov    = cov_sum[COV_W] ? {COV_W{1'b1}} : cov_sum[COV_W-1:0];
            upd.dcount = sat_add(cur.dcount, 2'd1);
        end
        upd.homref  = sat_add(cur.homref,  {1'b0, r_s1_homref});
        upd.het     = sat_add(cur.het,     {1'b0, r_s1_het});
        upd.homalt  = sat_add(cur.homalt,  {1'b0, r_s1_homalt});
        upd.missing = sat_add(cur.missing, {1'b0, r_s1_missing});
        upd.passing = sat_add(cur.passing, {1'b0, r_s1_pass});
        upd.ti      = sat_add(cur.ti, r_s1_ti);
        upd.tv      = sat_add(cur.tv, r_s1_tv);

        if (r_clearing) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = r_s1_valid && !r_s1_read && r_s1_en;
            wr_addr = r_s1_idx;
            wr_data = upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_fwd_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == IDX_W'(MAX_SAMPLES - 1))
                    r_clearing <= 1'b0;
            end
            if (wr_en)
                r_fwd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_fwd_addr <= wr_addr;
            r_fwd_data <= wr_data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            o_valid <= 1'b0;
        else if (s1_go && r_s1_read)
            o_valid <= 1'b1;
        else if (!i_stall)
            o_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_read) begin
            o_homref_total          <= cur.homref;
            o_het_total             <= cur.het;
            o_homalt_total          <= cur.homalt;
            o_missing_total         <= cur.missing;
            o_passing_variant_total <= cur.passing;
            o_transition_total      <= cur.ti;
            o_transversion_total    <= cur.tv;
            o_depth_sample_total    <= cur.dcount;
            o_coverage_total        <= cur.cov;
            o_site_total            <= r_s1_site;
        end
    end

endmodule

`default_nettype wire

// ===== src/pst_checker.sv =====
// Port-level checks for the per-sample genotype tally, bound to the top level.
// Depends on pst_pkg and per_sample_genotype_tally.
`timescale 1ns / 1ps
`default_nettype none

module pst_checker
    import pst_pkg::*;
(
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_valid,
    input wire               o_stall,
    input wire               i_opcode,
    input wire               o_valid,
    input wire               i_stall,
    input wire [CNT_W-1:0]   o_site_total,
    input wire [COV_W-1:0]   o_coverage_total
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_site_total) && $stable(o_coverage_total))
        else $error("result changed while stalled");

    // a new result follows an accepted read
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && !o_stall && i_opcode, 2))
        else $error("result without a read item");

    // the store is being cleared right after reset
    a_clear_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> o_stall)
        else $error("input open during store clear");

    // no result comes out of reset
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind per_sample_genotype_tally pst_checker u_pst_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_stall          (o_stall),
    .i_opcode         (i_opcode),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_site_total     (o_site_total),
    .o_coverage_total (o_coverage_total)
);

`default_nettype wire
